// ===== rtl/cfb_pkg.sv =====
// Shared types, constants and the CRC byte update for the CRC-16 frame builder.
package cfb_pkg;

   // Default parameter values
   localparam int unsigned MAX_PAYLOAD_DEF = 24;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // Field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CODE_W = 16;
   localparam int unsigned PLEN_W = 5;
   localparam int unsigned CRC_W  = 16;

   // Frame constants
   localparam logic [BYTE_W-1:0] SYNC_A       = 8'h5A;
   localparam logic [BYTE_W-1:0] SYNC_B       = 8'hA5;
   localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd5;
   localparam logic [CRC_W-1:0]  CRC_POLY     = 16'hA001;
   localparam logic [CRC_W-1:0]  CRC_PRESET   = 16'hFFFF;

   // Request kinds
   typedef enum logic {
      REQ_START = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   // Command handed from front to back
   typedef struct packed {
      req_kind_type       kind;
      logic [BYTE_W-1:0]  seq_byte;
      logic [CODE_W-1:0]  response_code;
      logic [PLEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last;
   } cmd_type;

   // Back end sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_CMD    = 8'b0000_0001,
      ST_SYNC_B = 8'b0000_0010,
      ST_LEN    = 8'b0000_0100,
      ST_SEQ    = 8'b0000_1000,
      ST_HI     = 8'b0001_0000,
      ST_LO     = 8'b0010_0000,
      ST_CRC_LO = 8'b0100_0000,
      ST_CRC_HI = 8'b1000_0000
   } back_state_type;

   // Reflected CRC-16/MODBUS update over one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/crc16_frame_builder.sv =====
// The first result byte passes through the command queue and then the output register.
// A start yields sync, length, sequence and two code bytes, and the CRC too if its payload
// is empty; a data byte yields itself, and the CRC too if last. Requests enter one per
// cycle until the command queue (QUEUE_DEPTH entries) fills; the back-end byte sequencer,
// emitting one byte per cycle while the receiver pops, sets the sustained rate. Reset is
// synchronous: it empties the queue and output register, closes any frame and presets the CRC.
module crc16_frame_builder
   import cfb_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] req_seq_byte,
   input  logic [CODE_W-1:0] req_response_code,
   input  logic [PLEN_W-1:0] req_payload_len,
   input  logic [BYTE_W-1:0] req_payload_byte,
   output logic              empty,
   input  logic              pop,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_frame_last
);

   logic    q_push, q_pop, q_empty, q_full;
   cmd_type q_wr_cmd, q_rd_cmd;

   cfb_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_kind_type'(req_type)),
      .req_seq_byte     (req_seq_byte),
      .req_response_code(req_response_code),
      .req_payload_len  (req_payload_len),
      .req_payload_byte (req_payload_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_wr_cmd)
   );

   cfb_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_data(q_wr_cmd),
      .rd_en  (q_pop),
      .rd_data(q_rd_cmd),
      .q_empty(q_empty),
      .q_full (q_full)
   );

   cfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (!q_empty),
      .cmd           (q_rd_cmd),
      .cmd_pop       (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_last(rsp_frame_last)
   );

`ifndef ASSERT_OFF
   // Front never queues into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command queued while queue full");

   // Back only takes a command that is present
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("command taken from empty queue");

   // The CRC high byte always closes the run of its request
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_last) |-> rsp_run_last)
      else $error("frame end without run end");

   // Reset leaves no result waiting
   assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");
`endif

endmodule

// ===== rtl/cfb_front.sv =====
// Front end: accepts requests, tracks the open frame and queues commands.
module cfb_front
   import cfb_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  req_kind_type      req_type,
   input  logic [BYTE_W-1:0] req_seq_byte,
   input  logic [CODE_W-1:0] req_response_code,
   input  logic [PLEN_W-1:0] req_payload_len,
   input  logic [BYTE_W-1:0] req_payload_byte,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   logic              frame_open_ff, frame_open_in;
   logic [PLEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic              accept;
   logic [PLEN_W-1:0] plen_sat;

   assign full   = q_full;
   assign accept = push && !q_full;

   // Clamp the declared length to the configured bound
   always_comb begin
      if ({3'b000, req_payload_len} > MaxLen) begin
         plen_sat = MaxLen[PLEN_W-1:0];
      end else begin
         plen_sat = req_payload_len;
      end
   end

   // Classify the transfer: start, data in frame, or drop
   always_comb begin
      frame_open_in       = frame_open_ff;
      bytes_left_in       = bytes_left_ff;
      q_push              = 1'b0;
      q_cmd.kind          = req_type;
      q_cmd.seq_byte      = req_seq_byte;
      q_cmd.response_code = req_response_code;
      q_cmd.payload_len   = plen_sat;
      q_cmd.payload_byte  = req_payload_byte;
      q_cmd.last          = (bytes_left_ff == PLEN_W'(1));
      if (accept) begin
         case (req_type)
            REQ_START: begin
               q_push        = 1'b1;
               frame_open_in = (plen_sat != '0);
               bytes_left_in = plen_sat;
            end
            REQ_DATA: begin
               if (frame_open_ff && (bytes_left_ff != '0)) begin
                  q_push        = 1'b1;
                  bytes_left_in = bytes_left_ff - PLEN_W'(1);
                  frame_open_in = (bytes_left_ff != PLEN_W'(1));
               end
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// ===== rtl/cfb_fifo.sv =====
// Small register queue of commands between front and back.
module cfb_fifo
   import cfb_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    q_empty,
   output logic    q_full
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == FullCnt);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/cfb_back.sv =====
// Back end: sequences frame bytes, runs the CRC and holds the result register.
module cfb_back
   import cfb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_frame_last
);

   back_state_type    state_ff, state_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   cmd_type           cur_ff, cur_in;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_run_ff, out_frame_ff;
   logic              advance;
   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_run, emit_frame;

   // Output register moves when empty or when its transfer completes
   assign advance        = !out_valid_ff || pop;
   assign empty          = !out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = out_run_ff;
   assign rsp_frame_last = out_frame_ff;

   // Byte sequencer
   always_comb begin
      state_in   = state_ff;
      crc_in     = crc_ff;
      cur_in     = cur_ff;
      cmd_pop    = 1'b0;
      emit       = 1'b0;
      emit_byte  = '0;
      emit_run   = 1'b0;
      emit_frame = 1'b0;
      if (advance) begin
         case (state_ff)
            ST_CMD: begin
               if (cmd_valid) begin
                  cmd_pop = 1'b1;
                  emit    = 1'b1;
                  if (cmd.kind == REQ_START) begin
                     cur_in    = cmd;
                     crc_in    = CRC_PRESET;
                     emit_byte = SYNC_A;
                     state_in  = ST_SYNC_B;
                  end else begin
                     emit_byte = cmd.payload_byte;
                     emit_run  = cmd.last;
                     crc_in    = crc_byte(crc_ff, cmd.payload_byte);
                     if (cmd.last) begin
                        state_in = ST_CRC_LO;
                     end
                  end
               end
            end
            ST_SYNC_B: begin
               emit      = 1'b1;
               emit_byte = SYNC_B;
               state_in  = ST_LEN;
            end
            ST_LEN: begin
               emit      = 1'b1;
               emit_byte = {3'b000, cur_ff.payload_len} + LEN_OVERHEAD;
               state_in  = ST_SEQ;
            end
            ST_SEQ: begin
               emit      = 1'b1;
               emit_byte = cur_ff.seq_byte;
               crc_in    = crc_byte(crc_ff, cur_ff.seq_byte);
               state_in  = ST_HI;
            end
            ST_HI: begin
               emit      = 1'b1;
               emit_byte = cur_ff.response_code[15:8];
               crc_in    = crc_byte(crc_ff, cur_ff.response_code[15:8]);
               state_in  = ST_LO;
            end
            ST_LO: begin
               emit      = 1'b1;
               emit_byte = cur_ff.response_code[7:0];
               emit_run  = (cur_ff.payload_len == '0);
               crc_in    = crc_byte(crc_ff, cur_ff.response_code[7:0]);
               state_in  = (cur_ff.payload_len == '0) ? ST_CRC_LO : ST_CMD;
            end
            ST_CRC_LO: begin
               emit      = 1'b1;
               emit_byte = crc_ff[7:0];
               state_in  = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               emit       = 1'b1;
               emit_byte  = crc_ff[15:8];
               emit_run   = 1'b1;
               emit_frame = 1'b1;
               state_in   = ST_CMD;
            end
            default: begin
               state_in = ST_CMD;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CMD;
         crc_ff       <= CRC_PRESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
         if (advance) begin
            out_valid_ff <= emit;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance && emit) begin
         out_byte_ff  <= emit_byte;
         out_run_ff   <= emit_run;
         out_frame_ff <= emit_frame;
      end
   end

endmodule

// ===== tb/crc16_frame_checker.sv =====
// Frame byte predictor and result scoreboard for the CRC-16 frame builder testbench.
module crc16_frame_checker
   import cfb_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] req_seq_byte,
   input  logic [CODE_W-1:0] req_response_code,
   input  logic [PLEN_W-1:0] req_payload_len,
   input  logic [BYTE_W-1:0] req_payload_byte,
   input  logic              empty,
   input  logic              pop,
   input  logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              rsp_run_last,
   input  logic              rsp_frame_last,
   output int unsigned       mismatches,
   output int unsigned       bytes_pending
);

   // One byte on the wire with its markers
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              run_last;
      logic              frame_last;
   } wire_byte_type;

   wire_byte_type     frame_bytes_due[$];
   wire_byte_type     got;
   wire_byte_type     want;
   int unsigned       errs = 0;

   // Shadow framer state
   logic [CRC_W-1:0]  crc_run = CRC_PRESET;
   logic [PLEN_W-1:0] left_cnt = '0;
   logic              open = 1'b0;

   // Reflected CRC-16 update, one input bit at a time, LSB first
   function automatic logic [CRC_W-1:0] crc_after(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] acc;
      logic             fb;
      acc = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb  = acc[0] ^ b[i];
         acc = acc >> 1;
         if (fb) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   task automatic due(input logic [BYTE_W-1:0] value, input logic rl, input logic fl);
      wire_byte_type w;
      w.value      = value;
      w.run_last   = rl;
      w.frame_last = fl;
      frame_bytes_due.push_back(w);
   endtask

   // CRC trailer, low byte first, closes the frame
   task automatic due_crc();
      due(crc_run[7:0], 1'b0, 1'b0);
      due(crc_run[15:8], 1'b1, 1'b1);
      open     = 1'b0;
      left_cnt = '0;
   endtask

   // Expected bytes for one accepted request
   task automatic predict_request();
      logic [PLEN_W-1:0] len;
      if (req_type == REQ_START) begin
         len = (req_payload_len > MAX_PAYLOAD) ? PLEN_W'(MAX_PAYLOAD) : req_payload_len;
         crc_run = crc_after(CRC_PRESET, req_seq_byte);
         crc_run = crc_after(crc_run, req_response_code[15:8]);
         crc_run = crc_after(crc_run, req_response_code[7:0]);
         due(SYNC_A, 1'b0, 1'b0);
         due(SYNC_B, 1'b0, 1'b0);
         due(BYTE_W'(len) + LEN_OVERHEAD, 1'b0, 1'b0);
         due(req_seq_byte, 1'b0, 1'b0);
         due(req_response_code[15:8], 1'b0, 1'b0);
         due(req_response_code[7:0], len == '0, 1'b0);
         if (len == '0) begin
            due_crc();
         end else begin
            left_cnt = len;
            open     = 1'b1;
         end
      end else if (open && left_cnt != '0) begin
         // stray data with no open frame is dropped
         crc_run  = crc_after(crc_run, req_payload_byte);
         left_cnt = left_cnt - PLEN_W'(1);
         due(req_payload_byte, left_cnt == '0, 1'b0);
         if (left_cnt == '0) begin
            due_crc();
         end
      end
   endtask

   task automatic report_field(input string name, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errs++;
         $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, exp_v, act_v);
      end
   endtask

   // Compare one result transfer with the oldest expectation
   task automatic check_result();
      got.value      = rsp_out_byte;
      got.run_last   = rsp_run_last;
      got.frame_last = rsp_frame_last;
      if (frame_bytes_due.size() == 0) begin
         errs++;
         $display("%0t: unexpected result: expected none, actual byte %02h",
                  $time, got.value);
         $display("   run_last %b frame_last %b", got.run_last, got.frame_last);
      end else begin
         want = frame_bytes_due.pop_front();
         report_field("out_byte", want.value, got.value);
         report_field("run_last", BYTE_W'(want.run_last), BYTE_W'(got.run_last));
         report_field("frame_last", BYTE_W'(want.frame_last), BYTE_W'(got.frame_last));
      end
   endtask

   // Watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         frame_bytes_due.delete();
         crc_run  = CRC_PRESET;
         left_cnt = '0;
         open     = 1'b0;
      end else begin
         if (pop && !empty) begin
            check_result();
         end
         if (push && !full) begin
            predict_request();
         end
      end
      bytes_pending <= frame_bytes_due.size();
      mismatches    <= errs;
   end

endmodule

// ===== tb/crc16_frame_builder_tb.sv =====
// Top-level testbench for the CRC-16 frame builder: stimulus, flow control and verdict.
module crc16_frame_builder_tb
   import cfb_pkg::*;
();

   localparam int unsigned RANDOM_ITEMS   = 230;
   localparam int unsigned HOLD_AT        = 60;
   localparam int unsigned PAUSE_AT       = 130;
   localparam int unsigned QUIET_AT       = 190;
   localparam int unsigned LONG_HOLD      = 150;
   localparam int unsigned DRAIN_CYCLES   = 24;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic              clock;
   logic              reset             = 1'b1;
   logic              push              = 1'b0;
   logic              full;
   logic              req_type          = REQ_START;
   logic [BYTE_W-1:0] req_seq_byte      = '0;
   logic [CODE_W-1:0] req_response_code = '0;
   logic [PLEN_W-1:0] req_payload_len   = '0;
   logic [BYTE_W-1:0] req_payload_byte  = '0;
   logic              empty;
   logic              pop               = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_run_last;
   logic              rsp_frame_last;

   int unsigned       mismatches;
   int unsigned       bytes_pending;
   int unsigned       items_sent  = 0;
   int unsigned       stall_count = 0;
   bit                hold_req    = 1'b0;
   bit                hold_taken  = 1'b0;
   bit                paused      = 1'b0;
   bit                quiet       = 1'b0;

   crc16_frame_builder u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_seq_byte      (req_seq_byte),
      .req_response_code (req_response_code),
      .req_payload_len   (req_payload_len),
      .req_payload_byte  (req_payload_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_frame_last    (rsp_frame_last)
   );

   crc16_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_seq_byte      (req_seq_byte),
      .req_response_code (req_response_code),
      .req_payload_len   (req_payload_len),
      .req_payload_byte  (req_payload_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_frame_last    (rsp_frame_last),
      .mismatches        (mismatches),
      .bytes_pending     (bytes_pending)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one request and hold it until the transfer, then maybe idle
   task automatic send_req(input req_kind_type kind, input logic [BYTE_W-1:0] seq,
                           input logic [CODE_W-1:0] code, input logic [PLEN_W-1:0] len,
                           input logic [BYTE_W-1:0] data);
      push              <= 1'b1;
      req_type          <= kind;
      req_seq_byte      <= seq;
      req_response_code <= code;
      req_payload_len   <= len;
      req_payload_byte  <= data;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic send_start(input logic [PLEN_W-1:0] len);
      send_req(REQ_START, BYTE_W'($urandom), CODE_W'($urandom), len, BYTE_W'($urandom));
   endtask

   task automatic send_data(input logic [BYTE_W-1:0] data);
      send_req(REQ_DATA, BYTE_W'($urandom), CODE_W'($urandom), PLEN_W'($urandom), data);
   endtask

   // Hold off until every expected byte has come out
   task automatic drain_all();
      push <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   // One random frame: mostly well formed, sometimes cut short or followed by strays
   task automatic random_frame();
      logic [PLEN_W-1:0] len;
      int unsigned       n_data;
      int unsigned       pick;
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         len = PLEN_W'($urandom_range(0, 6));
      end else if (pick < 19) begin
         len = PLEN_W'($urandom_range(7, MAX_PAYLOAD_DEF));
      end else begin
         len = PLEN_W'($urandom_range(MAX_PAYLOAD_DEF + 1, (1 << PLEN_W) - 1));
      end
      send_start(len);
      n_data = (len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : 32'(len);
      // abandon the frame early now and then; the next start restarts it
      if (n_data > 0 && $urandom_range(0, 9) == 0) begin
         n_data = $urandom_range(0, n_data - 1);
      end
      for (int unsigned i = 0; i < n_data; i++) begin
         send_data(BYTE_W'($urandom));
      end
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 2)) send_data(BYTE_W'($urandom));
      end
   endtask

   // Stimulus and verdict
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: stray byte after reset, empty payloads at field extremes
      send_data(8'hFF);
      send_req(REQ_START, 8'h00, 16'h0000, 5'd0, 8'h00);
      send_req(REQ_START, 8'hFF, 16'hFFFF, 5'd0, 8'hFF);
      // two-byte frame, then a stray byte past the declared length
      send_req(REQ_START, 8'h5A, 16'hA55A, 5'd2, 8'h00);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h77);
      // length above bound, abandoned by a restart
      send_req(REQ_START, 8'h12, 16'h8001, 5'd31, 8'hFF);
      send_data(8'h3C);
      send_data(8'hC3);
      send_req(REQ_START, 8'h7E, 16'hFF00, 5'd3, 8'h00);
      send_data(8'h01);
      send_data(8'h80);
      send_data(8'h55);
      // single-byte frame at the payload length extreme of one
      send_req(REQ_START, 8'h81, 16'h00FF, 5'd1, 8'h00);
      send_data(8'hAA);

      // random frames
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= HOLD_AT) begin
            hold_req = 1'b1;
         end
         if (items_sent >= PAUSE_AT && !paused) begin
            paused = 1'b1;
            drain_all();
         end
         if (items_sent >= QUIET_AT) begin
            quiet = 1'b1;
         end
         random_frame();
      end

      drain_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && bytes_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver: random pop bursts, one long hold-off counted here
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
      end
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

// ===== files.f =====
rtl/cfb_pkg.sv
rtl/cfb_front.sv
rtl/cfb_fifo.sv
rtl/cfb_back.sv
rtl/crc16_frame_builder.sv
tb/crc16_frame_checker.sv
tb/crc16_frame_builder_tb.sv
